>>> rtl/bbcd_pkg.sv
package bbcd_pkg;

   localparam int DATA_W = 32;
   localparam int CFG_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W = DATA_W + CFG_W;

   localparam logic [DATA_W-1:0] NO_DELAY_LIMIT = 32'h2000_0000;
   localparam logic [DATA_W-1:0] DIV_NO_DELAY = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] DIV_SLOWEST = 32'hFFFF_FFFE;

   localparam logic [CSR_IDX_W-1:0] CSR_CPU_FREQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERHEAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP = 2'd2;

   localparam logic [DATA_W-1:0] RST_CPU_FREQ = 32'd480000000;
   localparam logic [CFG_W-1:0] RST_OVERHEAD = 16'd27;
   localparam logic [CFG_W-1:0] RST_LOOP = 16'd2;

endpackage

>>> rtl/bbcd_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module bbcd_div
   import bbcd_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DATA_W-1:0] quotient,
   output logic [DATA_W-1:0] remainder,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [0:DATA_W];
   logic [DATA_W-1:0] rem_ff  [0:DATA_W];
   logic [DATA_W-1:0] qd_ff   [0:DATA_W];
   logic [DATA_W-1:0] den_ff  [0:DATA_W];
   logic [SIDE_W-1:0] side_ff [0:DATA_W];

   // Entry zero is the unregistered input of the first step.
   assign vld_ff[0]  = in_valid;
   assign rem_ff[0]  = '0;
   assign qd_ff[0]   = dividend;
   assign den_ff[0]  = divisor;
   assign side_ff[0] = in_side;

   for (genvar i = 0; i < DATA_W; i++) begin : g_step
      logic [DATA_W:0]   shifted;
      logic [DATA_W:0]   diff;
      logic              ge;
      logic [DATA_W-1:0] rem_in;
      logic [DATA_W-1:0] qd_in;

      always_comb begin
         shifted = {rem_ff[i], qd_ff[i][DATA_W-1]};
         diff    = shifted - {1'b0, den_ff[i]};
         ge      = ~diff[DATA_W];
         rem_in  = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         qd_in   = {qd_ff[i][DATA_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (en) begin
            rem_ff[i+1]  <= rem_in;
            qd_ff[i+1]   <= qd_in;
            den_ff[i+1]  <= den_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[DATA_W];
   assign quotient  = qd_ff[DATA_W];
   assign remainder = rem_ff[DATA_W];
   assign out_side  = side_ff[DATA_W];

endmodule

>>> rtl/bitbang_clock_divider_calc.sv
// Channel | Ports                          | Direction | Word
// req     | req_valid/req_ready            | in        | target_freq_hz
// rsp     | rsp_valid/rsp_ready            | out       | divider, achieved_freq_hz, div_fault
// csr     | csr_we/csr_index/csr_wdata     | in        | one register write, no handshake
//
// A new word is taken every cycle unless the output word stalls. Two 32-stage divider
// pipelines (one quotient bit per stage) follow stages A and C; the output is registered.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
// When the output word is not taken, the whole pipeline holds and req_ready drops.
module bitbang_clock_divider_calc
   import bbcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DATA_W-1:0]    req_target_freq_hz,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_divider,
   output logic [DATA_W-1:0]    rsp_achieved_freq_hz,
   output logic                 rsp_div_fault,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   logic [DATA_W-1:0] cpu_freq_ff;
   logic [CFG_W-1:0]  overhead_ff;
   logic [CFG_W-1:0]  loop_ff;

   // Configuration registers. Writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_freq_ff <= RST_CPU_FREQ;
         overhead_ff <= RST_OVERHEAD;
         loop_ff     <= RST_LOOP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CPU_FREQ: cpu_freq_ff <= csr_wdata;
            CSR_OVERHEAD: overhead_ff <= csr_wdata[CFG_W-1:0];
            CSR_LOOP:     loop_ff     <= csr_wdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together whenever the output slot is free or drains.
   logic adv;
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   // Stage A: both products of the target, truncated modulo 2^32.
   logic              a_vld_ff;
   logic [DATA_W-1:0] a_tgt_ff;
   logic [DATA_W-1:0] a_prod_ff;
   logic [DATA_W-1:0] a_m_ff;
   logic [PROD_W-1:0] a_prod_in;
   logic [PROD_W-1:0] a_m_in;

   always_comb begin
      a_prod_in = overhead_ff * req_target_freq_hz;
      a_m_in    = loop_ff * req_target_freq_hz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
      if (adv) begin
         a_tgt_ff  <= req_target_freq_hz;
         a_prod_ff <= a_prod_in[DATA_W-1:0];
         a_m_ff    <= a_m_in[DATA_W-1:0];
      end
   end

   // Divisor, its half, and the special cases that bypass the first division.
   logic [DATA_W-1:0] divisor;
   logic [DATA_W-1:0] half;
   logic [2:0]        d1_side_in;

   always_comb begin
      divisor    = cpu_freq_ff - a_prod_ff;
      half       = divisor >> 1;
      d1_side_in = {divisor >= NO_DELAY_LIMIT, a_tgt_ff == '0, a_m_ff == '0};
   end

   logic              d1_vld;
   logic [DATA_W-1:0] d1_q;
   logic [DATA_W-1:0] d1_r;
   logic [2:0]        d1_side;

   bbcd_div #(.SIDE_W(3)) u_div_loop (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (a_vld_ff),
      .dividend  (half),
      .divisor   (a_m_ff),
      .in_side   (d1_side_in),
      .out_valid (d1_vld),
      .quotient  (d1_q),
      .remainder (d1_r),
      .out_side  (d1_side)
   );

   // Stage B: round up and pick the divider.
   logic              b_vld_ff;
   logic [DATA_W-1:0] b_div_ff;
   logic              b_fault_ff;
   logic [DATA_W-1:0] b_div_in;
   logic              b_fault_in;

   always_comb begin
      b_fault_in = 1'b0;
      if (d1_side[2]) begin
         b_div_in = DIV_NO_DELAY;
      end else if (d1_side[1]) begin
         b_div_in = DIV_SLOWEST;
      end else if (d1_side[0]) begin
         b_div_in   = '0;
         b_fault_in = 1'b1;
      end else begin
         b_div_in = d1_q + {{(DATA_W-1){1'b0}}, d1_r != '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= d1_vld;
      end
      if (adv) begin
         b_div_ff   <= b_div_in;
         b_fault_ff <= b_fault_in;
      end
   end

   // Stage C: divider times loop cycles, modulo 2^32.
   logic              c_vld_ff;
   logic [DATA_W-1:0] c_div_ff;
   logic              c_fault_ff;
   logic [DATA_W-1:0] c_prod_ff;
   logic [PROD_W-1:0] c_prod_in;

   assign c_prod_in = b_div_ff * loop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
      if (adv) begin
         c_div_ff   <= b_div_ff;
         c_fault_ff <= b_fault_ff;
         c_prod_ff  <= c_prod_in[DATA_W-1:0];
      end
   end

   // Cycles per bit clock, which divides the core clock.
   logic [DATA_W-1:0] cpc;
   logic [DATA_W+1:0] d2_side_in;

   always_comb begin
      if (c_div_ff == DIV_NO_DELAY) begin
         cpc = {{(DATA_W-CFG_W){1'b0}}, overhead_ff};
      end else begin
         cpc = {{(DATA_W-CFG_W){1'b0}}, overhead_ff} + {c_prod_ff[DATA_W-2:0], 1'b0};
      end
      d2_side_in = {c_div_ff, c_fault_ff, cpc == '0};
   end

   logic              d2_vld;
   logic [DATA_W-1:0] d2_q;
   logic [DATA_W-1:0] d2_r;
   logic [DATA_W+1:0] d2_side;

   bbcd_div #(.SIDE_W(DATA_W + 2)) u_div_freq (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_vld_ff),
      .dividend  (cpu_freq_ff),
      .divisor   (cpc),
      .in_side   (d2_side_in),
      .out_valid (d2_vld),
      .quotient  (d2_q),
      .remainder (d2_r),
      .out_side  (d2_side)
   );

   // Output register. The remainder of the frequency division is not needed.
   logic              o_vld_ff;
   logic [DATA_W-1:0] o_div_ff;
   logic [DATA_W-1:0] o_freq_ff;
   logic              o_fault_ff;
   logic              o_fault_in;
   logic              unused_rem;

   assign o_fault_in = d2_side[1] | d2_side[0];
   assign unused_rem = ^d2_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= d2_vld;
      end
      if (adv) begin
         o_div_ff   <= d2_side[DATA_W+1:2];
         o_fault_ff <= o_fault_in;
         o_freq_ff  <= (o_fault_in | (unused_rem & 1'b0)) ? '0 : d2_q;
      end
   end

   assign rsp_valid            = o_vld_ff;
   assign rsp_divider          = o_div_ff;
   assign rsp_achieved_freq_hz = o_freq_ff;
   assign rsp_div_fault        = o_fault_ff;

endmodule

>>> rtl/bbcd_checker.sv
module bbcd_checker
   import bbcd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_divider,
   input logic [DATA_W-1:0] rsp_achieved_freq_hz,
   input logic              rsp_div_fault
);

   // A faulted word never reports a frequency.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_fault |-> rsp_achieved_freq_hz == '0)
      else $error("fault word carries a nonzero frequency");

   // A stalled output blocks new input.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

   // A stalled word stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_divider))
      else $error("stalled output word changed");

endmodule

bind bitbang_clock_divider_calc bbcd_checker u_bbcd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_divider          (rsp_divider),
   .rsp_achieved_freq_hz (rsp_achieved_freq_hz),
   .rsp_div_fault        (rsp_div_fault)
);
